[rtl/wdb_pkg.sv]
`timescale 1ns / 1ps
package wdb_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CHAN_W = 4;
	localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

	localparam logic [31:0] DEFAULT_TIMEOUT_RST = 32'd1000;
	localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;
	localparam logic [15:0] CHAN_CNT_MAX = 16'hFFFF;

	localparam logic [2:0] OP_CREATE = 3'd0;
	localparam logic [2:0] OP_ENABLE = 3'd1;
	localparam logic [2:0] OP_DISABLE = 3'd2;
	localparam logic [2:0] OP_KICK = 3'd3;
	localparam logic [2:0] OP_DELETE = 3'd4;
	localparam logic [2:0] OP_TICK = 3'd5;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_NO_SLOT = 2'd2;

	typedef enum logic [1:0] {
		CM_OFF = 2'd0,
		CM_ON = 2'd1,
		CM_TRIG = 2'd3
	} cmode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH
	} fsm_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] channel;
		logic [15:0] owner_id;
		logic [31:0] timeout;
		logic [2:0] recovery;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot;
		logic [15:0] expired_agent;
		logic [2:0] action;
		logic expired;
		logic [15:0] channel_expiries;
		logic [31:0] total_expiries;
		logic [4:0] active_count;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic create;
		logic enable;
		logic dis;
		logic kick;
		logic del;
		logic [CHAN_W-1:0] chan;
		logic [15:0] agent;
		logic [31:0] limit;
		logic [2:0] action;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		cmode_t mode;
		logic hit;
		logic [CHAN_W-1:0] slot;
		logic [15:0] agent;
		logic [2:0] action;
		logic [15:0] cexp;
	} cell_st_t;

endpackage

[rtl/wdb_if.sv]
`timescale 1ns / 1ps
interface wdb_req_if;
	import wdb_pkg::*;
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport mon (input valid, input data, input ready);
endinterface

interface wdb_rsp_if;
	import wdb_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport mon (input valid, input data, input ready);
endinterface

[rtl/wdb_cell.sv]
`timescale 1ns / 1ps
module wdb_cell import wdb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [CHAN_W-1:0] idx,
	input cmd_t cmd,
	input logic adv,
	input logic tok_in,
	output logic tok_out,
	output cell_st_t st
);

	cmode_t mode_q;
	logic tok_q;
	logic [15:0] agent_q;
	logic [31:0] limit_q;
	logic [31:0] kick_q;
	logic [2:0] action_q;
	logic [15:0] cnt_q;

	logic sel;
	logic hit;
	logic fire;
	logic [31:0] elapsed;
	logic [15:0] cnt_inc;

	assign sel = (cmd.chan == idx);
	assign elapsed = cmd.now - kick_q;
	assign hit = tok_q && (mode_q == CM_ON) && (elapsed >= limit_q);
	assign fire = hit && adv;
	assign cnt_inc = (cnt_q == CHAN_CNT_MAX) ? cnt_q : cnt_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= CM_OFF;
			tok_q <= 1'b0;
		end else begin
			if (adv) begin
				tok_q <= tok_in;
			end
			if (fire) begin
				mode_q <= CM_TRIG;
			end else if (sel) begin
				if (cmd.create || cmd.del) begin
					mode_q <= CM_OFF;
				end else if (cmd.enable) begin
					mode_q <= CM_ON;
				end else if (cmd.dis && (mode_q == CM_ON)) begin
					mode_q <= CM_OFF;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.create) begin
			agent_q <= cmd.agent;
			limit_q <= cmd.limit;
			action_q <= cmd.action;
		end
		if (sel && (cmd.create || cmd.enable || (cmd.kick && (mode_q == CM_ON)))) begin
			kick_q <= cmd.now;
		end
		if (sel && cmd.create) begin
			cnt_q <= 16'd0;
		end else if (fire) begin
			cnt_q <= cnt_inc;
		end
	end

	assign tok_out = tok_q;

	always_comb begin
		st.mode = mode_q;
		st.hit = hit;
		st.slot = idx;
		st.agent = agent_q;
		st.action = action_q;
		st.cexp = cnt_inc;
	end

endmodule

[rtl/multi_channel_watchdog_bank.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake        Payload
// req       in         valid / ready    mode, channel, owner_id, timeout, recovery
// rsp       out        valid / ready    status, slot, expiry fields, counts, last
// cfg       in         cfg_we           cfg_wdata (default timeout)
//
// Create, enable, disable, kick and delete requests each get a single response.
// A tick request passes a scan token down the row of channel cells, one cell a
// cycle unless the response side stalls, then a flush state sends the final response.
// Each expiry is held in a pending register so the final response can carry last.
// Reset clears all control state and disables every channel; no clearing pass is needed.
module multi_channel_watchdog_bank import wdb_pkg::*; (
	input logic clk,
	input logic arst_n,
	wdb_req_if.sink req,
	wdb_rsp_if.source rsp,
	input logic cfg_we,
	input logic [31:0] cfg_wdata
);

	fsm_t state_q;
	fsm_t state_d;

	logic [31:0] default_q;
	logic [31:0] tick_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] enabled_q;
	logic [CNT_W-1:0] enabled_d;
	logic [31:0] total_q;
	logic [31:0] total_inc;

	logic out_valid_q;
	rsp_t out_q;
	logic pend_valid_q;
	rsp_t pend_q;

	cmd_t cmd;
	cell_st_t cst [NUM_CHANNELS];
	logic [NUM_CHANNELS:0] tok;
	cell_st_t hit_st;
	logic hit_any;

	logic free;
	logic acc;
	logic adv;
	logic tick_start;
	logic full;
	logic found;
	cmode_t sel_mode;
	rsp_t cmd_rsp;
	rsp_t hit_rsp;
	rsp_t end_rsp;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_CHANNELS; gi++) begin : g_cell
			wdb_cell u_cell (
				.clk (clk),
				.arst_n (arst_n),
				.idx (CHAN_W'(gi)),
				.cmd (cmd),
				.adv (adv),
				.tok_in (tok[gi]),
				.tok_out (tok[gi+1]),
				.st (cst[gi])
			);
		end
	endgenerate

	assign tok[0] = tick_start;

	always_comb begin
		hit_st = '0;
		hit_any = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (tok[i+1]) begin
				hit_st = cst[i];
			end
			hit_any = hit_any | cst[i].hit;
		end
	end

	assign free = !out_valid_q || rsp.ready;
	assign acc = req.valid && req.ready;
	assign full = (used_q >= CNT_W'(NUM_CHANNELS));
	assign found = ({1'b0, req.data.channel} < used_q);
	assign sel_mode = cst[req.data.channel].mode;
	assign total_inc = (total_q == TOTAL_MAX) ? total_q : total_q + 32'd1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && (req.data.mode == OP_TICK)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (tok[NUM_CHANNELS] && adv) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE) && free;
		adv = !(hit_any && pend_valid_q && !free);
		tick_start = acc && (req.data.mode == OP_TICK);
	end

	always_comb begin
		cmd.create = acc && (req.data.mode == OP_CREATE) && !full;
		cmd.enable = acc && (req.data.mode == OP_ENABLE) && found;
		cmd.dis = acc && (req.data.mode == OP_DISABLE) && found;
		cmd.kick = acc && (req.data.mode == OP_KICK) && found;
		cmd.del = acc && (req.data.mode == OP_DELETE) && found;
		cmd.chan = (req.data.mode == OP_CREATE) ? used_q[CHAN_W-1:0] : req.data.channel;
		cmd.agent = req.data.owner_id;
		cmd.limit = (req.data.timeout != 32'd0) ? req.data.timeout : default_q;
		cmd.action = req.data.recovery;
		cmd.now = tick_q;
	end

	always_comb begin
		enabled_d = enabled_q;
		if (state_q == S_SCAN) begin
			if (hit_any && adv) begin
				enabled_d = enabled_q - CNT_W'(1);
			end
		end else if (cmd.enable && (sel_mode != CM_ON)) begin
			enabled_d = enabled_q + CNT_W'(1);
		end else if ((cmd.dis || cmd.del) && (sel_mode == CM_ON)) begin
			enabled_d = enabled_q - CNT_W'(1);
		end
	end

	always_comb begin
		cmd_rsp = '0;
		cmd_rsp.total_expiries = total_q;
		cmd_rsp.active_count = 5'(enabled_d);
		cmd_rsp.last = 1'b1;
		case (req.data.mode)
			OP_CREATE: begin
				if (full) begin
					cmd_rsp.status = STAT_NO_SLOT;
				end else begin
					cmd_rsp.slot = used_q[CHAN_W-1:0];
				end
			end
			OP_ENABLE, OP_DISABLE, OP_KICK, OP_DELETE: begin
				cmd_rsp.slot = req.data.channel;
				if (!found) begin
					cmd_rsp.status = STAT_NOT_FOUND;
				end
			end
			default: ;
		endcase

		hit_rsp = '0;
		hit_rsp.status = STAT_OK;
		hit_rsp.slot = hit_st.slot;
		hit_rsp.expired_agent = hit_st.agent;
		hit_rsp.action = hit_st.action;
		hit_rsp.expired = 1'b1;
		hit_rsp.channel_expiries = hit_st.cexp;
		hit_rsp.total_expiries = total_inc;
		hit_rsp.active_count = 5'(enabled_d);

		if (pend_valid_q) begin
			end_rsp = pend_q;
			end_rsp.last = 1'b1;
		end else begin
			end_rsp = '0;
			end_rsp.total_expiries = total_q;
			end_rsp.active_count = 5'(enabled_q);
			end_rsp.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			default_q <= DEFAULT_TIMEOUT_RST;
			tick_q <= '0;
			used_q <= '0;
			enabled_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			enabled_q <= enabled_d;
			if (cfg_we) begin
				default_q <= cfg_wdata;
			end
			if (tick_start) begin
				tick_q <= tick_q + 32'd1;
			end
			if (cmd.create) begin
				used_q <= used_q + CNT_W'(1);
			end
			if ((state_q == S_SCAN) && hit_any && adv) begin
				total_q <= total_inc;
				pend_valid_q <= 1'b1;
			end else if ((state_q == S_FLUSH) && free) begin
				pend_valid_q <= 1'b0;
			end
			if ((acc && (req.data.mode != OP_TICK))
					|| ((state_q == S_SCAN) && hit_any && adv && pend_valid_q)
					|| ((state_q == S_FLUSH) && free)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (req.data.mode != OP_TICK)) begin
			out_q <= cmd_rsp;
		end else if ((state_q == S_SCAN) && hit_any && adv && pend_valid_q) begin
			out_q <= pend_q;
		end else if ((state_q == S_FLUSH) && free) begin
			out_q <= end_rsp;
		end
		if ((state_q == S_SCAN) && hit_any && adv) begin
			pend_q <= hit_rsp;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

endmodule

[rtl/wdb_checker.sv]
`timescale 1ns / 1ps
module wdb_checker import wdb_pkg::*; (
	input logic clk,
	input logic arst_n,
	wdb_req_if.sink req,
	wdb_rsp_if.source rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("response changed while stalled");

	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.data.active_count <= 5'(NUM_CHANNELS))
		else $error("active count above channel count");

	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.expired |-> rsp.data.last)
		else $error("non-expiry response without last");

	a_req_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("request accepted while a response is stalled");

	a_expiry_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.expired |-> (rsp.data.channel_expiries != 16'd0)
			&& (rsp.data.total_expiries != 32'd0))
		else $error("expiry reported with zero count");

endmodule

bind multi_channel_watchdog_bank wdb_checker u_wdb_checker (
	.clk (clk),
	.arst_n (arst_n),
	.req (req),
	.rsp (rsp)
);
